### rtl/assert_macros.svh
// assertion helpers for the rtl, empty for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/omp_pkg.sv
package omp_pkg;

  localparam int MAX_OBSTACLES = 64;
  localparam int HISTORY_DEPTH = 4;
  localparam int OBS_AW        = $clog2(MAX_OBSTACLES);
  localparam int FILL_W        = 3;
  localparam int SAMPLE_W      = 64;
  localparam int HIST_W        = SAMPLE_W * HISTORY_DEPTH;
  localparam int WORD_W        = HIST_W + FILL_W;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [16:0] HEADING_LIMIT = 17'sd25736;
  localparam logic signed [41:0] DIFF_HI = 42'sd1099511627776;
  localparam logic signed [41:0] DIFF_LO = -42'sd1099511627777;

  localparam logic [16:0] RST_SPEED_HEADROOM = 17'd52429;
  localparam logic [16:0] RST_JERK_DECAY     = 17'd52429;
  localparam logic [16:0] RST_ACCEL_DECAY    = 17'd32768;
  localparam logic [30:0] RST_SPEED_CEILING  = 31'd98304;
  localparam logic [15:0] RST_STEP_INTERVAL  = 16'd6554;
  localparam logic [5:0]  RST_PRED_STEPS     = 6'd30;
  localparam logic [9:0]  RST_SAMPLE_RATE    = 10'd10;

  typedef enum logic [2:0] {
    CFG_HISTORY_MODE   = 3'd0,
    CFG_SAMPLE_RATE    = 3'd1,
    CFG_PRED_STEPS     = 3'd2,
    CFG_STEP_INTERVAL  = 3'd3,
    CFG_JERK_DECAY     = 3'd4,
    CFG_ACCEL_DECAY    = 3'd5,
    CFG_SPEED_CEILING  = 3'd6,
    CFG_SPEED_HEADROOM = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RLD, S_RMUL, S_KJ, S_KA, S_KE,
    S_SQX, S_SQY, S_SQS, S_SQRT, S_MAGD, S_LIM, S_LIM2,
    S_CINIT, S_CORD, S_CEND, S_OUT,
    S_PJX, S_PJY, S_PAX, S_PAY, S_PV,
    S_DMUL, S_DINIT, S_DIV, S_DEND,
    S_POSX, S_POSY, S_JX, S_JY, S_JE
  } st_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) return 32'sh7fffffff;
    if (v < -70'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
    logic signed [19:0] r;
    unique case (i)
      5'd0:  r = 20'sd51472;
      5'd1:  r = 20'sd30386;
      5'd2:  r = 20'sd16055;
      5'd3:  r = 20'sd8150;
      5'd4:  r = 20'sd4091;
      5'd5:  r = 20'sd2047;
      5'd6:  r = 20'sd1024;
      5'd7:  r = 20'sd512;
      5'd8:  r = 20'sd256;
      5'd9:  r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = 20'sd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/omp_ram.sv
module omp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/obstacle_motion_predictor_unit.sv
// Obstacle motion predictor. Each in_ transaction carries one observed position of one
// obstacle; its newest four samples and fill count live in a 64 x 259 bit RAM that is
// read, shifted and written back (no clearing pass: valid flops mark written entries).
// Until the history holds min(history_mode,2)+2 samples an item gives no result. Otherwise
// it gives prediction_steps+1 results (step 0 = current state, tlast on the final one)
// after the finite differences. Each result runs through one shared multiplier, a
// 2-bit-per-cycle square root and a CORDIC for the heading; each predicted step also
// needs a second square root, and when the speed limit clips it two restoring divisions.
// One item is worked on at a time; the next is accepted as soon as the last result sits in
// the output register.
module obstacle_motion_predictor_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // obstacle_id[5:0], pos_x[37:6], pos_y[69:38], zero fill
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_id[5:0], step_index[11:6], pred_x[43:12], pred_y[75:44], speed[107:76],
  // heading[123:108], zero fill
  output logic [127:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

`include "assert_macros.svh"

  // configuration
  logic [1:0]  hm_r;
  logic [9:0]  hz_r;
  logic [5:0]  nst_r;
  logic [15:0] dt_r;
  logic [16:0] jd_r, ad_r, hd_r;
  logic [30:0] ceil_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hm_r   <= 2'd0;
      hz_r   <= omp_pkg::RST_SAMPLE_RATE;
      nst_r  <= omp_pkg::RST_PRED_STEPS;
      dt_r   <= omp_pkg::RST_STEP_INTERVAL;
      jd_r   <= omp_pkg::RST_JERK_DECAY;
      ad_r   <= omp_pkg::RST_ACCEL_DECAY;
      ceil_r <= omp_pkg::RST_SPEED_CEILING;
      hd_r   <= omp_pkg::RST_SPEED_HEADROOM;
    end else if (cfg_valid && cfg_ready) begin
      unique case (omp_pkg::cfg_idx_t'(cfg_index))
        omp_pkg::CFG_HISTORY_MODE:   hm_r   <= cfg_data[1:0];
        omp_pkg::CFG_SAMPLE_RATE:    hz_r   <= cfg_data[9:0];
        omp_pkg::CFG_PRED_STEPS:     nst_r  <= cfg_data[5:0];
        omp_pkg::CFG_STEP_INTERVAL:  dt_r   <= cfg_data[15:0];
        omp_pkg::CFG_JERK_DECAY:     jd_r   <= cfg_data[16:0];
        omp_pkg::CFG_ACCEL_DECAY:    ad_r   <= cfg_data[16:0];
        omp_pkg::CFG_SPEED_CEILING:  ceil_r <= cfg_data;
        omp_pkg::CFG_SPEED_HEADROOM: hd_r   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic [16:0] jf, af, hr;
  logic [1:0]  mode;
  assign jf   = omp_pkg::ONE_Q16 - ((jd_r > omp_pkg::ONE_Q16) ? omp_pkg::ONE_Q16 : jd_r);
  assign af   = omp_pkg::ONE_Q16 - ((ad_r > omp_pkg::ONE_Q16) ? omp_pkg::ONE_Q16 : ad_r);
  assign hr   = (hd_r > omp_pkg::ONE_Q16) ? omp_pkg::ONE_Q16 : hd_r;
  assign mode = (hm_r > 2'd2) ? 2'd2 : hm_r;

  // history memory
  logic                          ram_we, ram_re;
  logic [omp_pkg::WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [omp_pkg::OBS_AW-1:0]    id_r, id_nxt;

  omp_ram #(.WIDTH(omp_pkg::WORD_W), .DEPTH(omp_pkg::MAX_OBSTACLES)) u_hist_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (id_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (in_tdata[omp_pkg::OBS_AW-1:0]),
    .rd_data (ram_rdata)
  );

  // state
  omp_pkg::st_t st_r, st_nxt;
  logic [omp_pkg::MAX_OBSTACLES-1:0] vld_r, vld_nxt;
  logic signed [31:0] inx_r, inx_nxt, iny_r, iny_nxt;
  logic signed [31:0] hx_r [omp_pkg::HISTORY_DEPTH];
  logic signed [31:0] hy_r [omp_pkg::HISTORY_DEPTH];
  logic signed [31:0] hx_nxt [omp_pkg::HISTORY_DEPTH];
  logic signed [31:0] hy_nxt [omp_pkg::HISTORY_DEPTH];
  logic [1:0]  mode_r, mode_nxt, order_r, order_nxt, iter_r, iter_nxt;
  logic        axis_r, axis_nxt, chk_r, chk_nxt;
  logic signed [41:0] d_r, d_nxt;
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [31:0] ax_r, ax_nxt, ay_r, ay_nxt, jx_r, jx_nxt, jy_r, jy_nxt;
  logic signed [33:0] jfdt_r, jfdt_nxt, afdt_r, afdt_nxt;
  logic [32:0] lim_r, lim_nxt;
  logic [31:0] spd_r, spd_nxt, m_r, m_nxt;
  logic [63:0] sq_r, sq_nxt, sqv_r, sqv_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [5:0]  cnt_r, cnt_nxt, k_r, k_nxt, steps_r, steps_nxt;
  logic signed [51:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [19:0] cz_r, cz_nxt;
  logic signed [15:0] head_r, head_nxt;
  logic [31:0] rem_r, rem_nxt, qn_r, qn_nxt;
  logic        neg_r, neg_nxt;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_r;
  logic        otv_r, otv_nxt, olast_r, olast_nxt;
  logic [127:0] odata_r, odata_nxt;

  assign in_tready  = (st_r == omp_pkg::S_IDLE);
  assign out_tvalid = otv_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // working combinational terms
  logic [omp_pkg::FILL_W-1:0] fill_old, fill_new;
  logic signed [35:0] s0, s1, s2, s3, diff;
  logic signed [52:0] dmul;
  logic [63:0] sq_t;
  logic signed [51:0] cdx, cdy;
  logic signed [19:0] zr;
  logic signed [16:0] hrnd;
  logic [32:0] dvt;
  logic [32:0] vabs;
  logic signed [31:0] vsel;

  always_comb begin
    st_nxt    = st_r;
    vld_nxt   = vld_r;
    id_nxt    = id_r;
    inx_nxt   = inx_r;
    iny_nxt   = iny_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    mode_nxt  = mode_r;
    order_nxt = order_r;
    iter_nxt  = iter_r;
    axis_nxt  = axis_r;
    chk_nxt   = chk_r;
    d_nxt     = d_r;
    px_nxt = px_r; py_nxt = py_r; vx_nxt = vx_r; vy_nxt = vy_r;
    ax_nxt = ax_r; ay_nxt = ay_r; jx_nxt = jx_r; jy_nxt = jy_r;
    jfdt_nxt  = jfdt_r;
    afdt_nxt  = afdt_r;
    lim_nxt   = lim_r;
    spd_nxt   = spd_r;
    m_nxt     = m_r;
    sq_nxt    = sq_r;
    sqv_nxt   = sqv_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    steps_nxt = steps_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    head_nxt  = head_r;
    rem_nxt   = rem_r;
    qn_nxt    = qn_r;
    neg_nxt   = neg_r;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = '0;
    otv_nxt   = otv_r && !out_tready;
    olast_nxt = olast_r;
    odata_nxt = odata_r;

    fill_old = vld_r[id_r] ? ram_rdata[omp_pkg::WORD_W-1 -: omp_pkg::FILL_W] : '0;
    fill_new = (fill_old >= omp_pkg::FILL_W'(omp_pkg::HISTORY_DEPTH)) ?
               omp_pkg::FILL_W'(omp_pkg::HISTORY_DEPTH) : fill_old + 1'b1;

    s0 = 36'(axis_r ? hy_r[0] : hx_r[0]);
    s1 = 36'(axis_r ? hy_r[1] : hx_r[1]);
    s2 = 36'(axis_r ? hy_r[2] : hx_r[2]);
    s3 = 36'(axis_r ? hy_r[3] : hx_r[3]);
    unique case (order_r)
      2'd1:    diff = s0 - s1;
      2'd2:    diff = s0 - (s1 <<< 1) + s2;
      2'd3:    diff = s0 - (s1 <<< 1) - s1 + (s2 <<< 1) + s2 - s3;
      default: diff = '0;
    endcase
    dmul = d_r * $signed({1'b0, hz_r});

    sq_t = res_r + bit_r;
    cdx  = cy_r >>> cnt_r[4:0];
    cdy  = cx_r >>> cnt_r[4:0];
    zr   = (cz_r + 20'sd4) >>> 3;
    hrnd = zr[16:0];
    dvt  = {rem_r, qn_r[31]};
    vsel = axis_r ? vy_r : vx_r;
    vabs = vsel[31] ? 33'd0 - 33'(vsel) : 33'(vsel);

    unique case (st_r)
      omp_pkg::S_IDLE: begin
        if (in_tvalid) begin
          ram_re  = 1'b1;
          id_nxt  = in_tdata[omp_pkg::OBS_AW-1:0];
          inx_nxt = in_tdata[37:6];
          iny_nxt = in_tdata[69:38];
          st_nxt  = omp_pkg::S_RD;
        end
      end
      omp_pkg::S_RD: begin
        // shift the new sample in, newest first
        hx_nxt[0] = inx_r;
        hy_nxt[0] = iny_r;
        for (int i = 1; i < omp_pkg::HISTORY_DEPTH; i++) begin
          hx_nxt[i] = ram_rdata[(i-1)*omp_pkg::SAMPLE_W +: 32];
          hy_nxt[i] = ram_rdata[(i-1)*omp_pkg::SAMPLE_W + 32 +: 32];
        end
        ram_we    = 1'b1;
        ram_wdata = {fill_new, ram_rdata[omp_pkg::HIST_W-omp_pkg::SAMPLE_W-1:0], iny_r, inx_r};
        vld_nxt[id_r] = 1'b1;
        mode_nxt  = mode;
        steps_nxt = nst_r;
        order_nxt = 2'd1;
        axis_nxt  = 1'b0;
        ax_nxt = '0; ay_nxt = '0; jx_nxt = '0; jy_nxt = '0;
        px_nxt = inx_r;
        py_nxt = iny_r;
        k_nxt  = '0;
        if (fill_new < omp_pkg::FILL_W'(mode) + 3'd2) st_nxt = omp_pkg::S_IDLE;
        else st_nxt = omp_pkg::S_RLD;
      end
      omp_pkg::S_RLD: begin
        d_nxt    = 42'(diff);
        iter_nxt = '0;
        st_nxt   = omp_pkg::S_RMUL;
      end
      omp_pkg::S_RMUL: begin
        if (iter_r != order_r) begin
          if (dmul > 53'(omp_pkg::DIFF_HI)) d_nxt = omp_pkg::DIFF_HI;
          else if (dmul < 53'(omp_pkg::DIFF_LO)) d_nxt = omp_pkg::DIFF_LO;
          else d_nxt = dmul[41:0];
          iter_nxt = iter_r + 1'b1;
        end else begin
          unique case ({axis_r, order_r})
            3'b001:  vx_nxt = omp_pkg::sat32(70'(d_r));
            3'b010:  ax_nxt = omp_pkg::sat32(70'(d_r));
            3'b011:  jx_nxt = omp_pkg::sat32(70'(d_r));
            3'b101:  vy_nxt = omp_pkg::sat32(70'(d_r));
            3'b110:  ay_nxt = omp_pkg::sat32(70'(d_r));
            3'b111:  jy_nxt = omp_pkg::sat32(70'(d_r));
            default: ;
          endcase
          if (order_r < mode_r + 2'd1) begin
            order_nxt = order_r + 1'b1;
            st_nxt    = omp_pkg::S_RLD;
          end else if (!axis_r) begin
            axis_nxt  = 1'b1;
            order_nxt = 2'd1;
            st_nxt    = omp_pkg::S_RLD;
          end else begin
            st_nxt = omp_pkg::S_KJ;
          end
        end
      end
      omp_pkg::S_KJ: begin
        mul_a  = 34'(jf);
        mul_b  = 34'(dt_r);
        st_nxt = omp_pkg::S_KA;
      end
      omp_pkg::S_KA: begin
        jfdt_nxt = prod_r[33:0];
        mul_a    = 34'(af);
        mul_b    = 34'(dt_r);
        st_nxt   = omp_pkg::S_KE;
      end
      omp_pkg::S_KE: begin
        afdt_nxt = prod_r[33:0];
        chk_nxt  = 1'b0;
        st_nxt   = omp_pkg::S_SQX;
      end
      omp_pkg::S_SQX: begin
        mul_a  = 34'(vx_r);
        mul_b  = 34'(vx_r);
        st_nxt = omp_pkg::S_SQY;
      end
      omp_pkg::S_SQY: begin
        sq_nxt = prod_r[63:0];
        mul_a  = 34'(vy_r);
        mul_b  = 34'(vy_r);
        st_nxt = omp_pkg::S_SQS;
      end
      omp_pkg::S_SQS: begin
        sqv_nxt = sq_r + prod_r[63:0];
        res_nxt = '0;
        bit_nxt = 64'd1 << 62;
        cnt_nxt = '0;
        st_nxt  = omp_pkg::S_SQRT;
      end
      omp_pkg::S_SQRT: begin
        if (sqv_r >= sq_t) begin
          sqv_nxt = sqv_r - sq_t;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd31) st_nxt = omp_pkg::S_MAGD;
      end
      omp_pkg::S_MAGD: begin
        if (chk_r) begin
          m_nxt    = res_r[31:0];
          axis_nxt = 1'b0;
          if ({1'b0, res_r[31:0]} > lim_r) st_nxt = omp_pkg::S_DMUL;
          else st_nxt = omp_pkg::S_POSX;
        end else begin
          spd_nxt = res_r[31:0];
          if (k_r == '0) st_nxt = omp_pkg::S_LIM;
          else st_nxt = omp_pkg::S_CINIT;
        end
      end
      omp_pkg::S_LIM: begin
        mul_a  = 34'(hr);
        mul_b  = 34'({1'b0, ceil_r}) - 34'(spd_r);
        st_nxt = omp_pkg::S_LIM2;
      end
      omp_pkg::S_LIM2: begin
        if ({1'b0, spd_r} < {1'b0, ceil_r}) lim_nxt = 33'(spd_r) + 33'(prod_r[67:16]);
        else lim_nxt = 33'(spd_r);
        st_nxt = omp_pkg::S_CINIT;
      end
      omp_pkg::S_CINIT: begin
        cnt_nxt = '0;
        if (vx_r == '0 && vy_r == '0) begin
          head_nxt = '0;
          st_nxt   = omp_pkg::S_OUT;
        end else begin
          // fold the left half plane by a quarter turn
          if (vx_r < 0 && vy_r >= 0) begin
            cx_nxt = 52'(vy_r) <<< 16;
            cy_nxt = -(52'(vx_r) <<< 16);
            cz_nxt = omp_pkg::HALF_PI_Q16;
          end else if (vx_r < 0) begin
            cx_nxt = -(52'(vy_r) <<< 16);
            cy_nxt = 52'(vx_r) <<< 16;
            cz_nxt = -omp_pkg::HALF_PI_Q16;
          end else begin
            cx_nxt = 52'(vx_r) <<< 16;
            cy_nxt = 52'(vy_r) <<< 16;
            cz_nxt = '0;
          end
          st_nxt = omp_pkg::S_CORD;
        end
      end
      omp_pkg::S_CORD: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + cdx;
          cy_nxt = cy_r - cdy;
          cz_nxt = cz_r + omp_pkg::atan_q16(cnt_r[4:0]);
        end else begin
          cx_nxt = cx_r - cdx;
          cy_nxt = cy_r + cdy;
          cz_nxt = cz_r - omp_pkg::atan_q16(cnt_r[4:0]);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd16) st_nxt = omp_pkg::S_CEND;
      end
      omp_pkg::S_CEND: begin
        if (hrnd > omp_pkg::HEADING_LIMIT) head_nxt = omp_pkg::HEADING_LIMIT[15:0];
        else if (hrnd < -omp_pkg::HEADING_LIMIT) head_nxt = 16'(-omp_pkg::HEADING_LIMIT);
        else head_nxt = hrnd[15:0];
        st_nxt = omp_pkg::S_OUT;
      end
      omp_pkg::S_OUT: begin
        if (!otv_r || out_tready) begin
          otv_nxt   = 1'b1;
          olast_nxt = (k_r == steps_r);
          odata_nxt = {4'd0, head_r, spd_r, py_r, px_r, k_r, id_r};
          if (k_r == steps_r) begin
            st_nxt = omp_pkg::S_IDLE;
          end else begin
            k_nxt  = k_r + 1'b1;
            st_nxt = omp_pkg::S_PJX;
          end
        end
      end
      omp_pkg::S_PJX: begin
        mul_a  = 34'(jx_r);
        mul_b  = jfdt_r;
        st_nxt = omp_pkg::S_PJY;
      end
      omp_pkg::S_PJY: begin
        ax_nxt = omp_pkg::sat32(70'(ax_r) + 70'(prod_r >>> 32));
        mul_a  = 34'(jy_r);
        mul_b  = jfdt_r;
        st_nxt = omp_pkg::S_PAX;
      end
      omp_pkg::S_PAX: begin
        ay_nxt = omp_pkg::sat32(70'(ay_r) + 70'(prod_r >>> 32));
        mul_a  = 34'(ax_r);
        mul_b  = afdt_r;
        st_nxt = omp_pkg::S_PAY;
      end
      omp_pkg::S_PAY: begin
        vx_nxt = omp_pkg::sat32(70'(vx_r) + 70'(prod_r >>> 32));
        mul_a  = 34'(ay_r);
        mul_b  = afdt_r;
        st_nxt = omp_pkg::S_PV;
      end
      omp_pkg::S_PV: begin
        vy_nxt  = omp_pkg::sat32(70'(vy_r) + 70'(prod_r >>> 32));
        chk_nxt = 1'b1;
        st_nxt  = omp_pkg::S_SQX;
      end
      omp_pkg::S_DMUL: begin
        mul_a   = 34'(vabs);
        mul_b   = 34'(lim_r);
        neg_nxt = vsel[31];
        st_nxt  = omp_pkg::S_DINIT;
      end
      omp_pkg::S_DINIT: begin
        // quotient stays below 2^31, so the high half is already below the divisor
        rem_nxt = prod_r[63:32];
        qn_nxt  = prod_r[31:0];
        cnt_nxt = '0;
        st_nxt  = omp_pkg::S_DIV;
      end
      omp_pkg::S_DIV: begin
        if (dvt >= {1'b0, m_r}) begin
          rem_nxt = 32'(dvt - {1'b0, m_r});
          qn_nxt  = {qn_r[30:0], 1'b1};
        end else begin
          rem_nxt = dvt[31:0];
          qn_nxt  = {qn_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 6'd31) st_nxt = omp_pkg::S_DEND;
      end
      omp_pkg::S_DEND: begin
        if (!axis_r) begin
          vx_nxt   = neg_r ? -$signed(qn_r) : $signed(qn_r);
          axis_nxt = 1'b1;
          st_nxt   = omp_pkg::S_DMUL;
        end else begin
          vy_nxt = neg_r ? -$signed(qn_r) : $signed(qn_r);
          st_nxt = omp_pkg::S_POSX;
        end
      end
      omp_pkg::S_POSX: begin
        mul_a  = 34'(vx_r);
        mul_b  = 34'(dt_r);
        st_nxt = omp_pkg::S_POSY;
      end
      omp_pkg::S_POSY: begin
        px_nxt = omp_pkg::sat32(70'(px_r) + 70'(prod_r >>> 16));
        mul_a  = 34'(vy_r);
        mul_b  = 34'(dt_r);
        st_nxt = omp_pkg::S_JX;
      end
      omp_pkg::S_JX: begin
        py_nxt = omp_pkg::sat32(70'(py_r) + 70'(prod_r >>> 16));
        mul_a  = 34'(jx_r);
        mul_b  = 34'(jf);
        st_nxt = omp_pkg::S_JY;
      end
      omp_pkg::S_JY: begin
        jx_nxt = prod_r[47:16];
        mul_a  = 34'(jy_r);
        mul_b  = 34'(jf);
        st_nxt = omp_pkg::S_JE;
      end
      omp_pkg::S_JE: begin
        jy_nxt  = prod_r[47:16];
        chk_nxt = 1'b0;
        st_nxt  = omp_pkg::S_SQX;
      end
      default: st_nxt = omp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= omp_pkg::S_IDLE;
      vld_r <= '0;
      otv_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
      otv_r <= otv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    id_r    <= id_nxt;
    inx_r   <= inx_nxt;
    iny_r   <= iny_nxt;
    hx_r    <= hx_nxt;
    hy_r    <= hy_nxt;
    mode_r  <= mode_nxt;
    order_r <= order_nxt;
    iter_r  <= iter_nxt;
    axis_r  <= axis_nxt;
    chk_r   <= chk_nxt;
    d_r     <= d_nxt;
    px_r <= px_nxt; py_r <= py_nxt; vx_r <= vx_nxt; vy_r <= vy_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; jx_r <= jx_nxt; jy_r <= jy_nxt;
    jfdt_r  <= jfdt_nxt;
    afdt_r  <= afdt_nxt;
    lim_r   <= lim_nxt;
    spd_r   <= spd_nxt;
    m_r     <= m_nxt;
    sq_r    <= sq_nxt;
    sqv_r   <= sqv_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    steps_r <= steps_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    head_r  <= head_nxt;
    rem_r   <= rem_nxt;
    qn_r    <= qn_nxt;
    neg_r   <= neg_nxt;
    olast_r <= olast_nxt;
    odata_r <= odata_nxt;
  end

  // divider remainder stays below the divisor
  `ASSERT_PROP(a_div_rem, clk, rst_n, (st_r == omp_pkg::S_DIV) |-> (rem_r < m_r))
  // a clipped component never exceeds the speed limit
  `ASSERT_PROP(a_clip_lim, clk, rst_n, (st_r == omp_pkg::S_DEND) |-> ({1'b0, qn_r} <= lim_r))
  // write-back marks the entry as holding history
  `ASSERT_PROP(a_vld_set, clk, rst_n, (st_r == omp_pkg::S_RD) |=> vld_r[$past(id_r)])

endmodule

### tb/sv/omp_checker.sv
module omp_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [71:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  id;
    logic [5:0]  step;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] spd;
    logic [15:0] hdg;
    logic        last;
  } motion_t;

  localparam longint DIFF_LIM = 64'sd1099511627776;
  localparam longint ONE = 65536;

  motion_t forecast_q[$];

  logic [1:0]  mode_r;
  logic [9:0]  hz_r;
  logic [5:0]  steps_r;
  logic [15:0] dt_r;
  logic [16:0] jdec_r, adec_r, hroom_r;
  logic [30:0] ceil_r;
  longint      hist[omp_pkg::MAX_OBSTACLES][omp_pkg::HISTORY_DEPTH][2];
  int          fill[omp_pkg::MAX_OBSTACLES];

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  function automatic longint sat32(longint v);
    return clamp_to(v, 64'sd2147483647);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag_of(longint vx, longint vy);
    return isqrt(longint'(vx * vx) + longint'(vy * vy));
  endfunction

  function automatic longint heading_of(longint vx, longint vy);
    longint x, y, z, t, dx, dy, r;
    x = vx * ONE;
    y = vy * ONE;
    z = 0;
    if (vx == 0 && vy == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(omp_pkg::atan_q16(i[4:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(omp_pkg::atan_q16(i[4:0]));
      end
    end
    r = (z + 4) >>> 3;
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r;
  endfunction

  // finite difference of the given order on one axis, scaled by hz^order
  function automatic longint diff_rate(int id, int ax, int order);
    longint d;
    case (order)
      1: d = hist[id][0][ax] - hist[id][1][ax];
      2: d = hist[id][0][ax] - 2 * hist[id][1][ax] + hist[id][2][ax];
      default: d = hist[id][0][ax] - 3 * hist[id][1][ax] + 3 * hist[id][2][ax]
                   - hist[id][3][ax];
    endcase
    for (int k = 0; k < order; k++) d = clamp_to(d * longint'(hz_r), DIFF_LIM);
    return sat32(d);
  endfunction

  function automatic motion_t make_result(int id, int k, longint px, longint py,
                                          longint vx, longint vy, bit lst);
    motion_t r;
    longint unsigned s;
    longint h;
    s = mag_of(vx, vy);
    h = heading_of(vx, vy);
    r.id = id[5:0];
    r.step = k[5:0];
    r.x = px[31:0];
    r.y = py[31:0];
    r.spd = (s > 64'hffffffff) ? 32'hffffffff : s[31:0];
    r.hdg = h[15:0];
    r.last = lst;
    return r;
  endfunction

  function automatic void add_forecast(motion_t r);
    forecast_q = {forecast_q, r};
  endfunction

  task automatic forecast(input logic [71:0] d);
    int id, md, steps;
    longint p[2], v[2], a[2], j[2], jf, af, hr, dt, lim, s, q;
    longint unsigned m, mg;
    id = d[5:0];
    for (int k = omp_pkg::HISTORY_DEPTH - 1; k >= 1; k--) begin
      hist[id][k][0] = hist[id][k-1][0];
      hist[id][k][1] = hist[id][k-1][1];
    end
    hist[id][0][0] = longint'(signed'(d[37:6]));
    hist[id][0][1] = longint'(signed'(d[69:38]));
    if (fill[id] < omp_pkg::HISTORY_DEPTH) fill[id]++;
    md = (mode_r > 2) ? 2 : mode_r;
    if (fill[id] < md + 2) return;
    for (int ax = 0; ax < 2; ax++) begin
      p[ax] = hist[id][0][ax];
      v[ax] = diff_rate(id, ax, 1);
      a[ax] = (md >= 1) ? diff_rate(id, ax, 2) : 0;
      j[ax] = (md >= 2) ? diff_rate(id, ax, 3) : 0;
    end
    steps = steps_r;
    add_forecast(make_result(id, 0, p[0], p[1], v[0], v[1], steps == 0));
    jf = ONE - ((jdec_r > ONE) ? ONE : longint'(jdec_r));
    af = ONE - ((adec_r > ONE) ? ONE : longint'(adec_r));
    hr = (hroom_r > ONE) ? ONE : longint'(hroom_r);
    dt = dt_r;
    s = longint'(mag_of(v[0], v[1]));
    lim = s;
    if (s < longint'(ceil_r)) lim = s + ((hr * (longint'(ceil_r) - s)) >>> 16);
    for (int k = 1; k <= steps; k++) begin
      for (int ax = 0; ax < 2; ax++) begin
        a[ax] = sat32(a[ax] + ((j[ax] * jf * dt) >>> 32));
        v[ax] = sat32(v[ax] + ((a[ax] * af * dt) >>> 32));
      end
      m = mag_of(v[0], v[1]);
      // scale both components down to the speed limit
      if (longint'(m) > lim) begin
        for (int ax = 0; ax < 2; ax++) begin
          mg = (v[ax] < 0) ? -v[ax] : v[ax];
          q = longint'((mg * longint'(lim)) / m);
          v[ax] = (v[ax] < 0) ? -q : q;
        end
      end
      for (int ax = 0; ax < 2; ax++) begin
        p[ax] = sat32(p[ax] + ((v[ax] * dt) >>> 16));
        j[ax] = (j[ax] * jf) >>> 16;
      end
      add_forecast(make_result(id, k, p[0], p[1], v[0], v[1], k == steps));
    end
  endtask

  always @(posedge clk) begin
    motion_t got, want;
    if (!rst_n) begin
      mode_r = 0;
      hz_r = omp_pkg::RST_SAMPLE_RATE;
      steps_r = omp_pkg::RST_PRED_STEPS;
      dt_r = omp_pkg::RST_STEP_INTERVAL;
      jdec_r = omp_pkg::RST_JERK_DECAY;
      adec_r = omp_pkg::RST_ACCEL_DECAY;
      ceil_r = omp_pkg::RST_SPEED_CEILING;
      hroom_r = omp_pkg::RST_SPEED_HEADROOM;
      foreach (fill[i]) fill[i] = 0;
      forecast_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (omp_pkg::cfg_idx_t'(cfg_index))
          omp_pkg::CFG_HISTORY_MODE:   mode_r = cfg_data[1:0];
          omp_pkg::CFG_SAMPLE_RATE:    hz_r = cfg_data[9:0];
          omp_pkg::CFG_PRED_STEPS:     steps_r = cfg_data[5:0];
          omp_pkg::CFG_STEP_INTERVAL:  dt_r = cfg_data[15:0];
          omp_pkg::CFG_JERK_DECAY:     jdec_r = cfg_data[16:0];
          omp_pkg::CFG_ACCEL_DECAY:    adec_r = cfg_data[16:0];
          omp_pkg::CFG_SPEED_CEILING:  ceil_r = cfg_data;
          omp_pkg::CFG_SPEED_HEADROOM: hroom_r = cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.id = out_tdata[5:0];
        got.step = out_tdata[11:6];
        got.x = out_tdata[43:12];
        got.y = out_tdata[75:44];
        got.spd = out_tdata[107:76];
        got.hdg = out_tdata[123:108];
        got.last = out_tlast;
        if (forecast_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: id %0d step %0d x %h y %h speed %h heading %h last %b",
                   $time, got.id, got.step, got.x, got.y, got.spd, got.hdg, got.last);
        end else begin
          want = forecast_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t mismatch expected: id %0d step %0d x %h y %h speed %h heading %h last %b",
                     $time, want.id, want.step, want.x, want.y, want.spd, want.hdg,
                     want.last);
            $display("%0t mismatch actual:   id %0d step %0d x %h y %h speed %h heading %h last %b",
                     $time, got.id, got.step, got.x, got.y, got.spd, got.hdg, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) forecast(in_tdata);
    end
    pending = forecast_q.size();
  end

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [71:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic [127:0]      out_tdata;
  logic              out_tlast;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  omp_pkg::cfg_idx_t cfg_index = omp_pkg::CFG_HISTORY_MODE;
  logic [30:0]       cfg_data = '0;
  int                errors, pending;
  logic              in_hs = 0, cfg_hs = 0;
  bit                quiet = 0;
  int                ready_hold = 0;
  int                cycles = 0;
  logic [31:0]       trk_x[4], trk_y[4], trk_vx[4], trk_vy[4];

  obstacle_motion_predictor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  omp_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_hs <= in_tvalid && in_tready;
    cfg_hs <= cfg_valid && cfg_ready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side stalls in random bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_tready = 1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready = 0;
      ready_hold = $urandom_range(0, 10);
    end else begin
      out_tready = 1;
    end
  end

  task automatic write_reg(input omp_pkg::cfg_idx_t idx, input logic [30:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(negedge clk); while (!cfg_hs);
    cfg_valid = 0;
  endtask

  task automatic write_all(input int md, hz, steps, dt, jd, ad, ceil, hr);
    write_reg(omp_pkg::CFG_HISTORY_MODE, 31'(md));
    write_reg(omp_pkg::CFG_SAMPLE_RATE, 31'(hz));
    write_reg(omp_pkg::CFG_PRED_STEPS, 31'(steps));
    write_reg(omp_pkg::CFG_STEP_INTERVAL, 31'(dt));
    write_reg(omp_pkg::CFG_JERK_DECAY, 31'(jd));
    write_reg(omp_pkg::CFG_ACCEL_DECAY, 31'(ad));
    write_reg(omp_pkg::CFG_SPEED_CEILING, 31'(ceil));
    write_reg(omp_pkg::CFG_SPEED_HEADROOM, 31'(hr));
  endtask

  task automatic send_obs(input logic [5:0] id, input logic [31:0] x, y);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {2'b00, y, x, id};
    do @(negedge clk); while (!in_hs);
  endtask

  // all results out, then room for an item that gives none
  task automatic drain;
    in_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic int pick_rate17();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_phase(input int n, input int max_steps);
    int hz, ceil, dt, id;
    logic [31:0] rx, ry;
    case ($urandom_range(0, 3))
      0: hz = 1;
      1: hz = 1000;
      2: hz = 0;
      default: hz = $urandom_range(1, 1000);
    endcase
    case ($urandom_range(0, 3))
      0: ceil = 0;
      1: ceil = 31'h7fffffff;
      2: ceil = $urandom_range(0, 1 << 22);
      default: ceil = $urandom() & 31'h7fffffff;
    endcase
    dt = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(1, 65535);
    write_all($urandom_range(0, 3), hz, $urandom_range(0, max_steps), dt,
              pick_rate17(), pick_rate17(), ceil, pick_rate17());
    for (int i = 0; i < 4; i++) begin
      trk_x[i] = $urandom();
      trk_y[i] = $urandom();
      trk_vx[i] = $urandom_range(0, 1 << 18) - (1 << 17);
      trk_vy[i] = $urandom_range(0, 1 << 18) - (1 << 17);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        // smooth track of one of a few obstacles
        id = $urandom_range(0, 3);
        trk_vx[id] += $urandom_range(0, 32767) - 16384;
        trk_vy[id] += $urandom_range(0, 32767) - 16384;
        trk_x[id] += trk_vx[id];
        trk_y[id] += trk_vy[id];
        send_obs(id[5:0], trk_x[id], trk_y[id]);
      end else begin
        rx = $urandom();
        ry = $urandom();
        send_obs(6'($urandom_range(0, 63)), rx, ry);
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // reset settings: standing obstacle, then one jumping across the whole range
    send_obs(0, 0, 0);
    send_obs(0, 0, 0);
    send_obs(1, 32'h7fffffff, 32'h7fffffff);
    send_obs(1, 32'h80000000, 32'h80000000);
    drain();

    // jerk with saturating differences, no predicted steps, jerk decay past one
    write_all(2, 1000, 0, 65535, 131071, 0, 31'h7fffffff, 65536);
    send_obs(3, 32'h7fffffff, 32'h80000000);
    send_obs(3, 32'h80000000, 32'h7fffffff);
    send_obs(3, 32'h7fffffff, 32'h80000000);
    send_obs(3, 32'h80000000, 32'h7fffffff);
    send_obs(4, 32'h00010000, 32'hffff0000);
    send_obs(4, 32'h00030000, 32'hfffd0000);
    send_obs(4, 32'h00060000, 32'hfffa0000);
    send_obs(4, 32'h000a0000, 32'hfff60000);
    drain();

    // mode three acts as jerk mode, zero sample rate gives no motion
    write_all(3, 0, 2, 6554, 0, 65536, 98304, 0);
    send_obs(5, 32'h12345678, 32'h87654321);
    send_obs(5, 32'h00000001, 32'hfffffffe);
    send_obs(5, 32'h55555555, 32'haaaaaaaa);
    send_obs(5, 32'hffffffff, 32'h00000000);
    drain();

    // zero speed limit: at rest but accelerating, no headroom
    write_all(1, 1000, 3, 65535, 0, 0, 1000, 0);
    send_obs(6, 32'h00010000, 32'h0);
    send_obs(6, 32'h0, 32'h0);
    send_obs(6, 32'h0, 32'h0);
    send_obs(63, 32'h0, 32'h0);
    send_obs(63, 32'hfffe0000, 32'h00020000);
    drain();

    random_phase(10, 63);
    for (int ph = 0; ph < 7; ph++) random_phase(45, 6);
    quiet = 1;
    random_phase(40, 6);

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/omp_pkg.sv
rtl/omp_ram.sv
rtl/obstacle_motion_predictor_unit.sv
tb/sv/omp_checker.sv
tb/sv/testbench.sv
